### rtl/matrix3x3_multiply_scale_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 matrix multiply and scale block
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef MATRIX3X3_MULTIPLY_SCALE_MACROS_SVH
`define MATRIX3X3_MULTIPLY_SCALE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MMS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mms assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mms assertion failed");

`endif

### rtl/mms_pkg.sv
// ----------------------------------------------------------------------------
// mms_pkg
// Types, codes and constants shared by the matrix multiply and scale block.
// ----------------------------------------------------------------------------
package mms_pkg;

  localparam int MatrixDim = 3;
  localparam int Cells     = MatrixDim * MatrixDim;
  localparam int DimW      = 2;
  localparam int CellIdxW  = 4;
  localparam int DataW     = 32;
  localparam int OpW       = 2;
  localparam int CfgIndexW = 2;

  localparam logic [OpW-1:0] OpLoadA   = 2'd0;
  localparam logic [OpW-1:0] OpLoadB   = 2'd1;
  localparam logic [OpW-1:0] OpCompute = 2'd2;

  localparam logic [CfgIndexW-1:0] CfgScaleEnable = 2'd0;
  localparam logic [CfgIndexW-1:0] CfgScaleCoef   = 2'd1;

  localparam logic signed [DataW-1:0] ScaleCoefReset = 32'sh0001_0000;

  typedef struct packed {
    logic [OpW-1:0]             operation;
    logic [CellIdxW-1:0]        element_index;
    logic signed [DataW-1:0]    element_value;
  } in_item_t;

  typedef struct packed {
    logic [DimW-1:0]            row;
    logic [DimW-1:0]            column;
    logic signed [DataW-1:0]    entry_value;
    logic                       saturated;
    logic                       last_entry;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_SCALE,
    ST_SCALE_DRAIN,
    ST_EMIT
  } ctl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                load_a;
    logic                load_b;
    logic [CellIdxW-1:0] load_index;
    logic                issue_mac;
    logic                first_term;
    logic [CellIdxW-1:0] rd_a_index;
    logic [CellIdxW-1:0] rd_b_index;
    logic                issue_scale;
    logic                emit;
    logic [DimW-1:0]     row;
    logic [DimW-1:0]     column;
    logic                last_entry;
  } dp_cmd_t;

  typedef struct packed {
    logic pipe_empty;
    logic out_free;
  } dp_status_t;

  function automatic logic [CellIdxW-1:0] cell_index(input logic [DimW-1:0] row,
                                                      input logic [DimW-1:0] col);
    return CellIdxW'(row) * CellIdxW'(MatrixDim) + CellIdxW'(col);
  endfunction

endpackage

### rtl/mms_in_if.sv
// ----------------------------------------------------------------------------
// mms_in_if
// Valid/ready channel carrying one input word of the matrix block.
// ----------------------------------------------------------------------------
interface mms_in_if;
  import mms_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/mms_out_if.sv
// ----------------------------------------------------------------------------
// mms_out_if
// Valid/ready channel carrying one result word of the matrix block.
// ----------------------------------------------------------------------------
interface mms_out_if;
  import mms_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/mms_controller.sv
// ----------------------------------------------------------------------------
// mms_controller
// Sequencer: decodes input words and walks the entries of the product matrix.
// ----------------------------------------------------------------------------
module mms_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  mms_pkg::in_item_t    in_item_i,
  output logic                 in_ready_o,
  input  logic                 scale_enable_i,
  input  mms_pkg::dp_status_t  status_i,
  output mms_pkg::dp_cmd_t     cmd_o
);
  import mms_pkg::*;

  ctl_state_e      state_q, state_d;
  logic [DimW-1:0] row_q, row_d;
  logic [DimW-1:0] col_q, col_d;
  logic [DimW-1:0] k_q, k_d;

  localparam logic [DimW-1:0] LastIdx = DimW'(MatrixDim - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
      col_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      k_q     <= k_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    col_d      = col_q;
    k_d        = k_q;
    in_ready_o = 1'b0;

    cmd_o             = '0;
    cmd_o.load_index  = in_item_i.element_index;
    cmd_o.rd_a_index  = cell_index(row_q, k_q);
    cmd_o.rd_b_index  = cell_index(k_q, col_q);
    cmd_o.first_term  = (k_q == '0);
    cmd_o.row         = row_q;
    cmd_o.column      = col_q;
    cmd_o.last_entry  = (row_q == LastIdx) && (col_q == LastIdx);

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (in_item_i.operation)
            OpLoadA: begin
              cmd_o.load_a = (in_item_i.element_index < CellIdxW'(Cells));
            end
            OpLoadB: begin
              cmd_o.load_b = (in_item_i.element_index < CellIdxW'(Cells));
            end
            OpCompute: begin
              row_d   = '0;
              col_d   = '0;
              k_d     = '0;
              state_d = ST_MAC;
            end
            default: ;
          endcase
        end
      end
      ST_MAC: begin
        cmd_o.issue_mac = 1'b1;
        if (k_q == LastIdx) begin
          k_d     = '0;
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + DimW'(1);
        end
      end
      ST_DRAIN: begin
        if (status_i.pipe_empty) begin
          state_d = scale_enable_i ? ST_SCALE : ST_EMIT;
        end
      end
      ST_SCALE: begin
        cmd_o.issue_scale = 1'b1;
        state_d           = ST_SCALE_DRAIN;
      end
      ST_SCALE_DRAIN: begin
        if (status_i.pipe_empty) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (cmd_o.last_entry) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_MAC;
            if (col_q == LastIdx) begin
              col_d = '0;
              row_d = row_q + DimW'(1);
            end else begin
              col_d = col_q + DimW'(1);
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### rtl/mms_datapath.sv
// ----------------------------------------------------------------------------
// mms_datapath
// Matrix stores, shared multiply pipeline, accumulator and output register.
// ----------------------------------------------------------------------------
module mms_datapath #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mms_pkg::dp_cmd_t                    cmd_i,
  input  logic signed [mms_pkg::DataW-1:0]    load_value_i,
  input  logic signed [mms_pkg::DataW-1:0]    scale_coef_i,
  output mms_pkg::dp_status_t                 status_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output mms_pkg::out_item_t                  out_item_o
);
  import mms_pkg::*;

  localparam int ProdW = 2 * DataW;
  localparam logic signed [ProdW-1:0] SatHi = ProdW'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [ProdW-1:0] SatLo = ProdW'(64'shFFFF_FFFF_8000_0000);
  localparam logic signed [DataW-1:0] MaxVal = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] MinVal = 32'sh8000_0000;

  logic signed [DataW-1:0] left_mem  [Cells];
  logic signed [DataW-1:0] right_mem [Cells];

  // Pipeline: operands, product, shifted and clipped term, accumulate.
  logic                    s1_valid_q, s2_valid_q, s3_valid_q;
  logic                    s1_scale_q, s2_scale_q, s3_scale_q;
  logic                    s1_first_q, s2_first_q, s3_first_q;
  logic signed [DataW-1:0] opa_q, opb_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [DataW-1:0] term_q, term_d;
  logic                    term_sat_q, term_sat_d;
  logic signed [ProdW-1:0] shifted;
  logic signed [DataW-1:0] acc_q, acc_d;
  logic                    flag_q, flag_d;
  logic signed [DataW:0]   sum;
  logic                    sum_ovf;
  logic                    out_valid_q;
  out_item_t               out_item_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_a) begin
      left_mem[cmd_i.load_index] <= load_value_i;
    end
    if (cmd_i.load_b) begin
      right_mem[cmd_i.load_index] <= load_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.issue_mac | cmd_i.issue_scale;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    shifted    = prod_q >>> FRACTION_BITS;
    term_sat_d = 1'b0;
    term_d     = shifted[DataW-1:0];
    if (shifted > SatHi) begin
      term_d     = MaxVal;
      term_sat_d = 1'b1;
    end else if (shifted < SatLo) begin
      term_d     = MinVal;
      term_sat_d = 1'b1;
    end
  end

  always_comb begin
    sum     = $signed({term_q[DataW-1], term_q}) + $signed({acc_q[DataW-1], acc_q});
    sum_ovf = sum[DataW] ^ sum[DataW-1];
    acc_d   = acc_q;
    flag_d  = flag_q;
    if (s3_valid_q) begin
      if (s3_scale_q) begin
        acc_d  = term_q;
        flag_d = flag_q | term_sat_q;
      end else if (s3_first_q) begin
        acc_d  = term_q;
        flag_d = term_sat_q;
      end else begin
        acc_d  = sum_ovf ? (sum[DataW] ? MinVal : MaxVal) : sum[DataW-1:0];
        flag_d = flag_q | term_sat_q | sum_ovf;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue_mac) begin
      opa_q <= left_mem[cmd_i.rd_a_index];
      opb_q <= right_mem[cmd_i.rd_b_index];
    end else if (cmd_i.issue_scale) begin
      opa_q <= acc_q;
      opb_q <= scale_coef_i;
    end
    s1_scale_q <= cmd_i.issue_scale;
    s1_first_q <= cmd_i.first_term;
    s2_scale_q <= s1_scale_q;
    s2_first_q <= s1_first_q;
    s3_scale_q <= s2_scale_q;
    s3_first_q <= s2_first_q;
    prod_q     <= opa_q * opb_q;
    term_q     <= term_d;
    term_sat_q <= term_sat_d;
    acc_q      <= acc_d;
    flag_q     <= flag_d;
    if (cmd_i.emit) begin
      out_item_q.row         <= cmd_i.row;
      out_item_q.column      <= cmd_i.column;
      out_item_q.entry_value <= acc_q;
      out_item_q.saturated   <= flag_q;
      out_item_q.last_entry  <= cmd_i.last_entry;
    end
  end

  assign status_o.pipe_empty = ~(s1_valid_q | s2_valid_q | s3_valid_q);
  assign status_o.out_free   = ~out_valid_q | out_ready_i;
  assign out_valid_o         = out_valid_q;
  assign out_item_o          = out_item_q;

endmodule

### rtl/matrix3x3_multiply_scale.sv
// ----------------------------------------------------------------------------
// matrix3x3_multiply_scale
// Fixed-point 3x3 matrix product with optional per-entry scaling.
//
//   Channel  Dir  Word                                   Handshake
//   in_i     in   operation, element_index, element_value valid/ready
//   out_o    out  row, column, entry_value, saturated,    valid/ready
//                 last_entry
//   cfg      in   cfg_we_i, cfg_index_i, cfg_data_i       write enable
//
// A load word is accepted whenever the block is idle. For each entry a compute
// word issues three multiply-accumulate terms, waits for the pipeline to drain
// and loads the output register once it is free; with scaling the sum passes
// once more through the single shared 32x32 multiply pipeline and drains first.
// Input is taken only between runs; the last result may still wait in the
// output register while new words are accepted. Reset clears control state.
// ----------------------------------------------------------------------------
module matrix3x3_multiply_scale #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mms_pkg::CfgIndexW-1:0]     cfg_index_i,
  input  logic [mms_pkg::DataW-1:0]         cfg_data_i,
  mms_in_if.sink                            in_i,
  mms_out_if.source                         out_o
);
  import mms_pkg::*;

  logic                    scale_enable_q;
  logic signed [DataW-1:0] scale_coef_q;
  dp_cmd_t                 cmd;
  dp_status_t              status;
  logic                    in_ready;
  out_item_t               out_item;
  logic                    out_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_enable_q <= 1'b0;
      scale_coef_q   <= ScaleCoefReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgScaleEnable: scale_enable_q <= cfg_data_i[0];
        CfgScaleCoef:   scale_coef_q   <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  mms_controller u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_i.valid),
    .in_item_i      (in_i.payload),
    .in_ready_o     (in_ready),
    .scale_enable_i (scale_enable_q),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  mms_datapath #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .load_value_i (in_i.payload.element_value),
    .scale_coef_i (scale_coef_q),
    .status_o     (status),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_o.ready),
    .out_item_o   (out_item)
  );

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid;
  assign out_o.payload = out_item;

endmodule

### rtl/mms_checker.sv
// ----------------------------------------------------------------------------
// mms_checker
// Port-level checks of the matrix block, bound to the top level.
// ----------------------------------------------------------------------------
`include "matrix3x3_multiply_scale_macros.svh"

module mms_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic [mms_pkg::OpW-1:0]         in_operation_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [mms_pkg::DimW-1:0]        out_row_i,
  input logic [mms_pkg::DimW-1:0]        out_column_i,
  input logic [mms_pkg::DataW-1:0]       out_entry_value_i,
  input logic                            out_last_entry_i
);
  import mms_pkg::*;

  localparam logic [DimW-1:0] LastIdx = DimW'(MatrixDim - 1);

  // A stalled result word keeps its value.
  `MMS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_entry_value_i) && $stable(out_last_entry_i))

  // The final word of a run is the bottom-right entry.
  `MMS_ASSERT_SAME(a_last_corner, clk_i, rst_ni, out_valid_i && out_last_entry_i, out_row_i == LastIdx && out_column_i == LastIdx)

  // A compute word closes the input until the run is done.
  `MMS_ASSERT_NEXT(a_compute_blocks, clk_i, rst_ni, in_valid_i && in_ready_i && in_operation_i == OpCompute, !in_ready_i)

  // Row and column stay inside the matrix.
  `MMS_ASSERT_SAME(a_pos_range, clk_i, rst_ni, out_valid_i, out_row_i <= LastIdx && out_column_i <= LastIdx)

endmodule

bind matrix3x3_multiply_scale mms_checker u_mms_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .in_operation_i    (in_i.payload.operation),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_row_i         (out_o.payload.row),
  .out_column_i      (out_o.payload.column),
  .out_entry_value_i (out_o.payload.entry_value),
  .out_last_entry_i  (out_o.payload.last_entry)
);

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for matrix3x3_multiply_scale
// Loads the left and right matrices a word at a time, issues compute words
// and checks every emitted entry against a fixed-point predictor of the
// product, under a series of scale settings and random flow control.
// ----------------------------------------------------------------------------
module testbench;
  import mms_pkg::*;

  localparam int           ClkPeriod  = 4;
  localparam int           FracBits   = 16;
  localparam int           IdleCycles = 20;
  localparam int           TailCycles = 150;
  localparam int           NumPhases  = 8;
  localparam int           PhaseWords = 39;
  localparam longint       WordMax    = 64'sd2147483647;
  localparam longint       WordMin    = -64'sd2147483648;

  // Codes the block must ignore.
  localparam logic [OpW-1:0]       OpReserved    = 2'd3;
  localparam logic [CfgIndexW-1:0] CfgUnusedLow  = 2'd2;
  localparam logic [CfgIndexW-1:0] CfgUnusedHigh = 2'd3;

  class product_scoreboard;
    logic signed [DataW-1:0] left_m [Cells];
    logic signed [DataW-1:0] right_m [Cells];
    bit                      scale_on;
    logic signed [DataW-1:0] scale_coef;
    out_item_t               pending_entries [$];
    int unsigned             mismatches;
    int unsigned             entries_checked;
    int unsigned             loads;
    int unsigned             computes;
    int unsigned             ignored;

    function new();
      foreach (left_m[n]) begin
        left_m[n]  = '0;
        right_m[n] = '0;
      end
      scale_on        = 1'b0;
      scale_coef      = ScaleCoefReset;
      mismatches      = 0;
      entries_checked = 0;
      loads           = 0;
      computes        = 0;
      ignored         = 0;
    endfunction

    function void set_register(logic [CfgIndexW-1:0] idx, logic [DataW-1:0] data);
      case (idx)
        CfgScaleEnable: scale_on = data[0];
        CfgScaleCoef:   scale_coef = data;
        default: ;
      endcase
    endfunction

    function longint clip_word(longint v, inout bit clipped);
      if (v > WordMax) begin
        clipped = 1'b1;
        return WordMax;
      end
      if (v < WordMin) begin
        clipped = 1'b1;
        return WordMin;
      end
      return v;
    endfunction

    // The arithmetic shift of the exact product rounds toward minus infinity.
    function longint fixed_mul(longint a, longint b, inout bit clipped);
      longint prod;
      prod = a * b;
      return clip_word(prod >>> FracBits, clipped);
    endfunction

    function void predict_product();
      out_item_t entry;
      longint    acc;
      longint    term;
      bit        clipped;
      for (int i = 0; i < MatrixDim; i++) begin
        for (int j = 0; j < MatrixDim; j++) begin
          clipped = 1'b0;
          acc     = 0;
          for (int k = 0; k < MatrixDim; k++) begin
            term = fixed_mul(left_m[i*MatrixDim+k], right_m[k*MatrixDim+j], clipped);
            acc  = clip_word(acc + term, clipped);
          end
          if (scale_on) begin
            acc = fixed_mul(acc, scale_coef, clipped);
          end
          entry.row         = DimW'(i);
          entry.column      = DimW'(j);
          entry.entry_value = acc[DataW-1:0];
          entry.saturated   = clipped;
          entry.last_entry  = (i == MatrixDim - 1) && (j == MatrixDim - 1);
          pending_entries.push_back(entry);
        end
      end
    endfunction

    function void note_word(in_item_t w);
      case (w.operation)
        OpLoadA, OpLoadB: begin
          if (w.element_index < Cells) begin
            loads++;
            if (w.operation == OpLoadA) begin
              left_m[w.element_index] = w.element_value;
            end else begin
              right_m[w.element_index] = w.element_value;
            end
          end else begin
            ignored++;
          end
        end
        OpCompute: begin
          computes++;
          predict_product();
        end
        default: ignored++;
      endcase
    endfunction

    function void check_entry(out_item_t got);
      out_item_t want;
      if (pending_entries.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result word with nothing expected: row %0d col %0d value %h",
                   $time, got.row, got.column, got.entry_value);
        end
        return;
      end
      want = pending_entries.pop_front();
      entries_checked++;
      if (got.row !== want.row || got.column !== want.column ||
          got.entry_value !== want.entry_value || got.saturated !== want.saturated ||
          got.last_entry !== want.last_entry) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: entry mismatch: expected (%0d,%0d) %h sat %b last %b",
                   $time, want.row, want.column, want.entry_value, want.saturated,
                   want.last_entry);
          $display("%0t:                   got (%0d,%0d) %h sat %b last %b",
                   $time, got.row, got.column, got.entry_value, got.saturated,
                   got.last_entry);
        end
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [DataW-1:0]     cfg_data_i;

  mms_in_if  in_ch ();
  mms_out_if out_ch ();

  product_scoreboard sb = new();

  matrix3x3_multiply_scale DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Mostly small Q16.16 values so sums stay in range, with extremes and
  // full-width noise mixed in to hit the clipping paths.
  function automatic logic signed [DataW-1:0] random_element();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sh0000_0000;
          3: return 32'shFFFF_FFFF;
          4: return 32'sh0001_0000;
          default: return 32'shFFFF_0000;
        endcase
      end
      1, 2: return $urandom;
      default: return int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  function automatic logic signed [DataW-1:0] directed_element(bit right_side, int n);
    if (!right_side) begin
      case (n)
        0: return 32'sh7FFF_FFFF;
        1: return 32'sh8000_0000;
        2: return 32'sh0001_0000;
        3: return 32'shFFFF_FFFF;
        4: return 32'sh0000_0000;
        5: return 32'sh0002_8000;
        6: return 32'shFFFE_0000;
        7: return 32'sh0000_0001;
        default: return 32'sh7FFF_0000;
      endcase
    end
    case (n)
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh0001_0000;
      2: return 32'sh8000_0000;
      3: return 32'sh0001_0000;
      4: return 32'sh8000_0000;
      5: return 32'sh0000_0000;
      6: return 32'shFFFF_0000;
      7: return 32'sh0000_4000;
      default: return 32'sh8000_0001;
    endcase
  endfunction

  // Called right after a rising edge; returns at the edge that takes the word.
  task automatic send_word(in_item_t w);
    in_ch.valid   <= 1'b1;
    in_ch.payload <= w;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_word(w);
  endtask

  task automatic idle_gap(int unsigned cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending_entries.size() != 0) @(posedge clk_i);
    repeat (IdleCycles) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CfgIndexW-1:0] idx, logic [DataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    sb.set_register(idx, data);
    @(posedge clk_i);
  endtask

  // The unused indexes get junk on every pass; the block must ignore it.
  task automatic configure(bit enable, logic signed [DataW-1:0] coef);
    write_register(CfgScaleEnable, {{(DataW-1){1'b0}}, enable});
    write_register(CfgScaleCoef, coef);
    write_register(CfgUnusedLow, $urandom);
    write_register(CfgUnusedHigh, $urandom);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(int unsigned quota, bit bursty);
    in_item_t    w;
    int unsigned counted;
    int unsigned burst;
    int unsigned pick;
    counted = 0;
    burst   = $urandom_range(1, 16);
    while (counted < quota) begin
      pick            = $urandom_range(0, 99);
      w.element_value = random_element();
      w.element_index = CellIdxW'($urandom_range(0, Cells - 1));
      if (pick < 10) begin
        w.operation = OpCompute;
      end else if (pick < 50) begin
        w.operation = OpLoadA;
      end else if (pick < 90) begin
        w.operation = OpLoadB;
      end else if (pick < 95) begin
        w.operation     = OpReserved;
        w.element_index = CellIdxW'($urandom_range(0, 15));
      end else begin
        w.operation     = $urandom_range(0, 1) ? OpLoadB : OpLoadA;
        w.element_index = CellIdxW'($urandom_range(Cells, 15));
      end
      if (pick < 90) counted++;
      send_word(w);
      if (bursty) begin
        burst--;
        if (burst == 0) begin
          idle_gap($urandom_range(1, 10));
          burst = $urandom_range(1, 16);
        end
      end
    end
  endtask

  // Receiver: it steps through four stall patterns in turn: always ready, mostly ready, random and rarely ready.
  initial begin
    int unsigned tick;
    tick = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        sb.check_entry(out_ch.payload);
      end
      tick++;
      case ((tick >> 8) % 4)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= (tick % 4) != 0;
        2: out_ch.ready <= $urandom_range(0, 1);
        default: out_ch.ready <= (tick % 8) == 0;
      endcase
    end
  end

  initial begin
    in_item_t                w;
    logic signed [DataW-1:0] coef;
    bit                      enable;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset scale settings.
    for (int n = 0; n < Cells; n++) begin
      w.operation     = OpLoadA;
      w.element_index = CellIdxW'(n);
      w.element_value = directed_element(1'b0, n);
      send_word(w);
    end
    for (int n = 0; n < Cells; n++) begin
      w.operation     = OpLoadB;
      w.element_index = CellIdxW'(n);
      w.element_value = directed_element(1'b1, n);
      send_word(w);
    end
    w.operation = OpCompute;
    send_word(w);
    w = '{operation: OpReserved, element_index: 4'hF, element_value: 32'sh7FFF_FFFF};
    send_word(w);
    // Loads past the last cell must leave both matrices untouched.
    w = '{operation: OpLoadA, element_index: 4'd9, element_value: 32'sh1234_5678};
    send_word(w);
    w = '{operation: OpLoadB, element_index: 4'hF, element_value: 32'sh8765_4321};
    send_word(w);
    w = '{operation: OpCompute, element_index: 4'hA, element_value: 32'shFFFF_FFFF};
    send_word(w);
    wait_drained();

    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: begin enable = 1'b1; coef = ScaleCoefReset; end
        1: begin enable = 1'b1; coef = 32'sh8000_0000; end
        2: begin enable = 1'b1; coef = 32'sh7FFF_FFFF; end
        3: begin enable = 1'b0; coef = $urandom; end
        4: begin enable = 1'b1; coef = 32'sh0000_0000; end
        5: begin enable = 1'b1; coef = int'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000; end
        6: begin enable = 1'b1; coef = $urandom; end
        default: begin enable = 1'b1; coef = 32'shFFFF_0000; end
      endcase
      configure(enable, coef);
      run_phase(PhaseWords, (phase % 3) != 0);
      wait_drained();
    end

    repeat (TailCycles) @(posedge clk_i);
    $display("Run covered %0d loads, %0d computes and %0d ignored words over %0d scale settings.",
             sb.loads, sb.computes, sb.ignored, NumPhases + 1);
    $display("Checked %0d result entries; %0d mismatches.", sb.entries_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_entries.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d result entries outstanding.", sb.pending_entries.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/mms_pkg.sv
rtl/mms_in_if.sv
rtl/mms_out_if.sv
rtl/mms_controller.sv
rtl/mms_datapath.sv
rtl/matrix3x3_multiply_scale.sv
rtl/mms_checker.sv
tb/testbench.sv
